// File: hdl/dht11_pulse_frame_decoder_core_macros.svh
// Assertion macros shared by the decoder RTL.
`ifndef DHT11_PULSE_FRAME_DECODER_CORE_MACROS_SVH
`define DHT11_PULSE_FRAME_DECODER_CORE_MACROS_SVH

// Same-cycle implication under reset.
`define DHTPFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under reset.
`define DHTPFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/dhtpfd_pkg.sv
package dhtpfd_pkg;

	localparam int unsigned ThreshBits = 16;
	localparam int unsigned PosBits = 6;

	localparam logic [PosBits-1:0] HumLastBit = 6'd7;
	localparam logic [PosBits-1:0] TempLastBit = 6'd23;
	localparam logic [PosBits-1:0] FrameLastBit = 6'd39;

	localparam logic CfgStartThreshold = 1'b0;
	localparam logic CfgOneThreshold = 1'b1;

	localparam logic [ThreshBits-1:0] StartThresholdRst = 16'd80;
	localparam logic [ThreshBits-1:0] OneThresholdRst = 16'd40;

	typedef struct packed {
		logic [7:0] humidity;
		logic [7:0] temperature;
		logic [7:0] checksum;
		logic       checksum_ok;
	} result_t;

endpackage

// File: hdl/dhtpfd_frame.sv
module dhtpfd_frame (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  step,
	input  logic [dhtpfd_pkg::ThreshBits-1:0]     pulse_width,
	input  logic [dhtpfd_pkg::ThreshBits-1:0]     start_threshold,
	input  logic [dhtpfd_pkg::ThreshBits-1:0]     one_threshold,
	output logic                                  res_valid,
	output dhtpfd_pkg::result_t                   res
);

	logic [dhtpfd_pkg::PosBits-1:0] bit_pos_q;
	logic [7:0]                     byte_shift_q;
	logic [7:0]                     hum_hold_q;
	logic [7:0]                     temp_hold_q;

	logic       is_start;
	logic       is_data;
	logic [7:0] shift_next;
	logic [8:0] sum;

	always_comb begin
		is_start = (pulse_width >= start_threshold);
		is_data = !is_start && (bit_pos_q <= dhtpfd_pkg::FrameLastBit);
		shift_next = byte_shift_q;
		shift_next[3'd7 - bit_pos_q[2:0]] = (pulse_width > one_threshold);
		sum = {1'b0, hum_hold_q} + {1'b0, temp_hold_q};
		res_valid = is_data && (bit_pos_q == dhtpfd_pkg::FrameLastBit);
		res.humidity = hum_hold_q;
		res.temperature = temp_hold_q;
		res.checksum = shift_next;
		res.checksum_ok = ({1'b0, shift_next} == sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_pos_q <= '0;
			byte_shift_q <= '0;
			hum_hold_q <= '0;
			temp_hold_q <= '0;
		end else if (step) begin
			if (is_start) begin
				bit_pos_q <= '0;
			end else if (is_data) begin
				bit_pos_q <= bit_pos_q + 6'd1;
				byte_shift_q <= shift_next;
				if (bit_pos_q == dhtpfd_pkg::HumLastBit) begin
					hum_hold_q <= shift_next;
				end
				if (bit_pos_q == dhtpfd_pkg::TempLastBit) begin
					temp_hold_q <= shift_next;
				end
			end
		end
	end

endmodule

// File: hdl/dht11_pulse_frame_decoder_core.sv
// DHT11 single-wire frame decoder. Each input word is one measured high-pulse
// width in timer ticks; only its low WIDTH_BITS bits count. A width at or above
// start_threshold restarts the frame, a shorter one is a data bit (1 when above
// one_threshold), packed MSB first. On the fortieth data bit one output word
// carries humidity (byte 0), temperature (byte 2), the received checksum
// (byte 4) and checksum_ok, set when the checksum equals the unwrapped sum of
// humidity and temperature. Data pulses after that are dropped until the next
// start. One input word is taken every clock while in_stall is low: a word is
// registered, decoded from that register and lands in the output register,
// or in the skid entry when the output register is held. A two-entry output
// buffer keeps input flowing while out_stall is high; input stalls only when
// both entries are full. Thresholds reset to 80 and 40 and must be written
// while the block is idle.
module dht11_pulse_frame_decoder_core #(
	parameter int unsigned WIDTH_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] pulse_width,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  humidity,
	output logic [7:0]  temperature,
	output logic [7:0]  checksum,
	output logic        checksum_ok
);

	`include "dht11_pulse_frame_decoder_core_macros.svh"

	localparam int unsigned UsedBits =
		(WIDTH_BITS < dhtpfd_pkg::ThreshBits) ? WIDTH_BITS : dhtpfd_pkg::ThreshBits;

	logic [dhtpfd_pkg::ThreshBits-1:0] start_thresh_q;
	logic [dhtpfd_pkg::ThreshBits-1:0] one_thresh_q;

	logic                              valid_s1;
	logic [dhtpfd_pkg::ThreshBits-1:0] width_s1;

	logic                 out_valid_q;
	dhtpfd_pkg::result_t  out_q;
	logic                 skid_valid_q;
	dhtpfd_pkg::result_t  skid_q;

	logic                 advance;
	logic                 pop;
	logic                 res_valid;
	dhtpfd_pkg::result_t  res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_thresh_q <= dhtpfd_pkg::StartThresholdRst;
			one_thresh_q <= dhtpfd_pkg::OneThresholdRst;
		end else if (cfg_we) begin
			case (cfg_index)
				dhtpfd_pkg::CfgStartThreshold: start_thresh_q <= cfg_data;
				dhtpfd_pkg::CfgOneThreshold:   one_thresh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance = valid_s1 && !skid_valid_q;
	assign in_stall = valid_s1 && skid_valid_q;
	assign pop = out_valid_q && !out_stall;

	// hold the input word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			width_s1 <= dhtpfd_pkg::ThreshBits'(pulse_width[UsedBits-1:0]);
		end
	end

	dhtpfd_frame u_frame (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (advance),
		.pulse_width     (width_s1),
		.start_threshold (start_thresh_q),
		.one_threshold   (one_thresh_q),
		.res_valid       (res_valid),
		.res             (res)
	);

	// output register plus skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (pop) begin
					out_valid_q <= 1'b1;
					skid_valid_q <= 1'b0;
				end
			end else if (advance && res_valid) begin
				if (out_valid_q && !pop) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (advance && res_valid) begin
			if (out_valid_q && !pop) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign humidity = out_q.humidity;
	assign temperature = out_q.temperature;
	assign checksum = out_q.checksum;
	assign checksum_ok = out_q.checksum_ok;

	`DHTPFD_ASSERT_NOW(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q,
		"skid entry full while output register empty")
	`DHTPFD_ASSERT_NEXT(a_blocked_word_kept, clk, arst_n, valid_s1 && skid_valid_q,
		valid_s1, "input word lost while output buffer full")
	`DHTPFD_ASSERT_NOW(a_flag_matches, clk, arst_n, out_valid_q,
		checksum_ok == ({1'b0, checksum} == ({1'b0, humidity} + {1'b0, temperature})),
		"checksum flag disagrees with result bytes")

endmodule

// File: tb/sv/dht11_frame_checker.sv
module dht11_frame_checker #(
	parameter int unsigned WIDTH_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [15:0] pulse_width,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  humidity,
	input  logic [7:0]  temperature,
	input  logic [7:0]  checksum,
	input  logic        checksum_ok,
	output int          fails,
	output int          pending,
	output int          frames_checked,
	output int          good_sums
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [15:0]         start_level;
	logic [15:0]         one_level;
	logic [5:0]          next_bit;
	logic [7:0]          shift_byte;
	logic [7:0]          hum_byte;
	logic [7:0]          temp_byte;
	dhtpfd_pkg::result_t frame_results [$];

	function automatic void decode_pulse(input logic [15:0] raw);
		logic [31:0]         w;
		logic [5:0]          pos;
		dhtpfd_pkg::result_t r;
		w = {16'd0, raw};
		if (WIDTH_BITS < 16) begin
			w = w & ((32'd1 << WIDTH_BITS) - 32'd1);
		end
		pos = next_bit;
		if (w >= {16'd0, start_level}) begin
			next_bit = '0;
			return;
		end
		if (pos > dhtpfd_pkg::FrameLastBit) begin
			return;
		end
		shift_byte[3'd7 - pos[2:0]] = (w > {16'd0, one_level});
		next_bit = pos + 6'd1;
		if (pos == dhtpfd_pkg::HumLastBit) begin
			hum_byte = shift_byte;
		end
		if (pos == dhtpfd_pkg::TempLastBit) begin
			temp_byte = shift_byte;
		end
		if (pos == dhtpfd_pkg::FrameLastBit) begin
			r.humidity = hum_byte;
			r.temperature = temp_byte;
			r.checksum = shift_byte;
			r.checksum_ok = ({1'b0, shift_byte} == {1'b0, hum_byte} + {1'b0, temp_byte});
			frame_results.push_back(r);
		end
	endfunction

	task automatic check_field(input string name, input logic [7:0] want_v,
			input logic [7:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		dhtpfd_pkg::result_t got;
		dhtpfd_pkg::result_t want;
		if (!arst_n) begin
			start_level = dhtpfd_pkg::StartThresholdRst;
			one_level = dhtpfd_pkg::OneThresholdRst;
			next_bit = '0;
			shift_byte = '0;
			hum_byte = '0;
			temp_byte = '0;
			frame_results.delete();
			fails = 0;
			pending = 0;
			frames_checked = 0;
			good_sums = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got.humidity = humidity;
				got.temperature = temperature;
				got.checksum = checksum;
				got.checksum_ok = checksum_ok;
				if (frame_results.size() == 0) begin
					$error("result word with nothing expected: hum %0d temp %0d sum %0d ok %0d",
						humidity, temperature, checksum, checksum_ok);
					fails++;
				end else begin
					want = frame_results.pop_front();
					check_field("humidity", want.humidity, got.humidity);
					check_field("temperature", want.temperature, got.temperature);
					check_field("checksum", want.checksum, got.checksum);
					check_field("checksum_ok", 8'(want.checksum_ok), 8'(got.checksum_ok));
					frames_checked++;
					if (want.checksum_ok) begin
						good_sums++;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == dhtpfd_pkg::CfgStartThreshold) begin
					start_level = cfg_data;
				end else begin
					one_level = cfg_data;
				end
			end
			if (in_valid && !in_stall) begin
				decode_pulse(pulse_width);
			end
			pending = frame_results.size();
		end
	end

endmodule

// File: tb/sv/dht11_pulse_frame_decoder_core_tb.sv
module dht11_pulse_frame_decoder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned WIDTH_BITS = 16;
	localparam int PHASE_WORDS = 160;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = dhtpfd_pkg::CfgStartThreshold;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] pulse_width = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  humidity;
	logic [7:0]  temperature;
	logic [7:0]  checksum;
	logic        checksum_ok;

	int fail_count;
	int pending_count;
	int frames_checked;
	int good_sums;

	bit          gaps_on = 1'b1;
	int          words_sent = 0;
	int          settings_run = 0;
	logic [15:0] start_thr = dhtpfd_pkg::StartThresholdRst;
	logic [15:0] one_thr = dhtpfd_pkg::OneThresholdRst;

	dht11_pulse_frame_decoder_core #(
		.WIDTH_BITS(WIDTH_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pulse_width(pulse_width),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.humidity(humidity),
		.temperature(temperature),
		.checksum(checksum),
		.checksum_ok(checksum_ok)
	);

	dht11_frame_checker #(
		.WIDTH_BITS(WIDTH_BITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pulse_width(pulse_width),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.humidity(humidity),
		.temperature(temperature),
		.checksum(checksum),
		.checksum_ok(checksum_ok),
		.fails(fail_count),
		.pending(pending_count),
		.frames_checked(frames_checked),
		.good_sums(good_sums)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(negedge clk) begin
		out_stall <= gaps_on && ($urandom_range(0, 99) < 28);
	end

	initial begin
		#5ms;
		$display("timeout: decoder stopped making progress");
		$display("*** FAILED ***");
		$finish;
	end

	// width that decodes as the given data bit under the current thresholds, or a random width when none exists
	function automatic logic [15:0] bit_width(input bit one);
		int lo;
		int hi;
		if (one) begin
			lo = int'(one_thr) + 1;
			hi = int'(start_thr) - 1;
		end else begin
			lo = 0;
			hi = (int'(one_thr) < int'(start_thr) - 1) ? int'(one_thr) : int'(start_thr) - 1;
		end
		if (lo > hi) begin
			return 16'($urandom);
		end
		case ($urandom_range(0, 3))
			0: return 16'(lo);
			1: return 16'(hi);
			default: return 16'($urandom_range(hi, lo));
		endcase
	endfunction

	function automatic logic [15:0] start_width();
		case ($urandom_range(0, 3))
			0: return start_thr;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(65535, start_thr));
		endcase
	endfunction

	task automatic send_pulse(input logic [15:0] w);
		while (gaps_on && $urandom_range(0, 99) < 28) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pulse_width <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_threshold(input logic idx, input logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (idx == dhtpfd_pkg::CfgStartThreshold) begin
			start_thr = v;
		end else begin
			one_thr = v;
		end
	endtask

	task automatic send_frame(input int nbits, input bit tail);
		logic [7:0]  hum;
		logic [7:0]  temp;
		logic [7:0]  csum;
		logic [39:0] bits;
		int          extra;
		hum = 8'($urandom);
		temp = 8'($urandom);
		case ($urandom_range(0, 3))
			0: begin
				hum = 8'($urandom_range(0, 127));
				temp = 8'($urandom_range(0, 128));
				csum = hum + temp;
			end
			1: csum = hum + temp;
			2: csum = 8'($urandom);
			default: begin
				hum = 8'($urandom_range(255, 160));
				temp = 8'($urandom_range(255, 96));
				csum = hum + temp;
			end
		endcase
		bits = {hum, 8'($urandom), temp, 8'($urandom), csum};
		send_pulse(start_width());
		for (int i = 0; i < nbits; i++) begin
			send_pulse(bit_width(bits[39 - i]));
		end
		words_sent += nbits + 1;
		// trailing pulses after a full frame are dropped by the block
		if (tail) begin
			extra = $urandom_range(0, 3);
			repeat (extra) send_pulse(bit_width(1'($urandom_range(0, 1))));
		end
	endtask

	task automatic run_phase(input logic [15:0] s, input logic [15:0] o);
		int stop_at;
		int pick;
		stop_at = words_sent + PHASE_WORDS;
		drain();
		set_threshold(dhtpfd_pkg::CfgStartThreshold, s);
		set_threshold(dhtpfd_pkg::CfgOneThreshold, o);
		settings_run++;
		while (words_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				send_frame(40, 1'b1);
			end else if (pick < 85) begin
				send_frame($urandom_range(1, 39), 1'b0);
			end else begin
				send_pulse($urandom_range(0, 1) ? 16'($urandom) :
					bit_width(1'($urandom_range(0, 1))));
				words_sent++;
			end
			if ($urandom_range(0, 99) < 4) begin
				drain();
			end
		end
	endtask

	initial begin : stimulus
		logic [15:0] probes [14];
		int waited;
		probes = '{16'd41, 16'd40, 16'd0, 16'd79, 16'd1, 16'd39, 16'd80,
			16'hFFFF, 16'hAAAA, 16'h5555, 16'd78, 16'd42, 16'd81, 16'd40};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// data before any start, then both sides of each threshold
		foreach (probes[i]) begin
			send_pulse(probes[i]);
			words_sent++;
		end

		run_phase(16'd80, 16'd40);
		run_phase(16'd0, 16'd0);
		run_phase(16'hFFFF, 16'hFFFF);
		run_phase(16'hFFFF, 16'd0);
		gaps_on = 1'b0;
		run_phase(16'd1000, 16'd500);
		gaps_on = 1'b1;
		run_phase(16'd2, 16'd0);
		run_phase(16'd200, 16'd198);
		run_phase(16'h8000, 16'h7FFE);
		run_phase(16'd80, 16'd40);

		in_valid <= 1'b0;
		waited = 0;
		while (pending_count != 0 && waited < 2000) begin
			@(negedge clk);
			waited++;
		end
		repeat (6) @(negedge clk);
		if (pending_count != 0) begin
			$error("%0d frame results never arrived", pending_count);
		end

		$display("Sent %0d pulse words under %0d threshold settings.", words_sent, settings_run);
		$display("Checked %0d frame results, %0d of them with a matching checksum.",
			frames_checked, good_sums);
		if (fail_count == 0 && pending_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
